@@ src/art_pkg.sv @@
package art_pkg;

   localparam int ADDR_IN_W = 40;
   localparam int SLOT_W    = 5;
   localparam int OUTCOME_W = 2;

   localparam logic [7:0] FREE_BYTE = 8'h30;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_PRESENT  = 2'd0,
      OUT_RECORDED = 2'd1,
      OUT_FULL     = 2'd2
   } art_outcome_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } art_mem_ctl_type;

endpackage

@@ src/art_mem.sv @@
module art_mem #(
   parameter int DEPTH  = 15,
   parameter int IDX_W  = 4,
   parameter int DATA_W = 40
) (
   input  logic                     clock,
   input  logic                     reset,
   input  art_pkg::art_mem_ctl_type mem_ctl,
   input  logic [IDX_W-1:0]         rd_addr,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   output logic [DATA_W-1:0]        rd_data
);
   import art_pkg::*;

   localparam logic [DATA_W-1:0] FREE_PATTERN = {(DATA_W / 8){FREE_BYTE}};

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;

   // Entries never written since reset read as the all-free pattern.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : FREE_PATTERN;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/art_ctrl.sv @@
module art_ctrl #(
   parameter int SLOTS  = 16,
   parameter int CNT_W  = 4,
   parameter int IDX_W  = 4,
   parameter int DATA_W = 40
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [art_pkg::ADDR_IN_W-1:0]   req_node_address,
   output logic                            rsp_strobe,
   output logic [art_pkg::SLOT_W-1:0]      rsp_slot_index,
   output logic [art_pkg::OUTCOME_W-1:0]   rsp_outcome,
   output art_pkg::art_mem_ctl_type        mem_ctl,
   output logic [IDX_W-1:0]                rd_addr,
   output logic [IDX_W-1:0]                wr_addr,
   output logic [DATA_W-1:0]               wr_data,
   input  logic [DATA_W-1:0]               rd_data
);
   import art_pkg::*;

   localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0]  LAST_IDX  = CNT_W'(SLOTS - 2);
   localparam logic [SLOT_W-1:0] FULL_CODE = SLOT_W'(SLOTS);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type         state_ff;
   logic [DATA_W-1:0] addr_ff;
   logic [CNT_W-1:0]  issue_cnt_ff;
   logic              cmp_vld_ff;
   logic [CNT_W-1:0]  cmp_idx_ff;
   logic              free_found_ff;
   logic [CNT_W-1:0]  free_idx_ff;
   logic              rsp_strobe_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   art_outcome_type   rsp_outcome_ff;

   logic              issue_more;
   logic              hit;
   logic              slot_free;
   logic              scan_last;
   logic              free_any;
   logic [CNT_W-1:0]  free_sel;

   always_comb begin
      issue_more = (state_ff == ST_SCAN) && (issue_cnt_ff < LAST_CNT);
      hit        = cmp_vld_ff && (rd_data == addr_ff);
      slot_free  = rd_data[DATA_W-1 -: 8] == FREE_BYTE;
      scan_last  = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);
      free_any   = free_found_ff || (cmp_vld_ff && slot_free);
      free_sel   = free_found_ff ? free_idx_ff : cmp_idx_ff;
   end

   assign mem_ctl.rd_en = issue_more;
   assign mem_ctl.wr_en = scan_last && !hit && free_any;
   assign rd_addr       = issue_cnt_ff[IDX_W-1:0];
   assign wr_addr       = free_sel[IDX_W-1:0];
   assign wr_data       = addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_cnt_ff  <= '0;
         cmp_vld_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               rsp_strobe_ff <= 1'b0;
               if (start) begin
                  addr_ff       <= DATA_W'(req_node_address);
                  issue_cnt_ff  <= '0;
                  cmp_vld_ff    <= 1'b0;
                  free_found_ff <= 1'b0;
                  state_ff      <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               rsp_strobe_ff <= hit || scan_last;
               cmp_vld_ff    <= issue_more && !hit;
               cmp_idx_ff    <= issue_cnt_ff;
               if (issue_more) begin
                  issue_cnt_ff <= issue_cnt_ff + 1'b1;
               end
               if (cmp_vld_ff && slot_free && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= cmp_idx_ff;
               end
               if (hit) begin
                  rsp_slot_ff    <= SLOT_W'({1'b0, cmp_idx_ff} + (CNT_W + 1)'(1));
                  rsp_outcome_ff <= OUT_PRESENT;
                  state_ff       <= ST_IDLE;
               end else if (scan_last) begin
                  if (free_any) begin
                     rsp_slot_ff    <= SLOT_W'({1'b0, free_sel} + (CNT_W + 1)'(1));
                     rsp_outcome_ff <= OUT_RECORDED;
                  end else begin
                     rsp_slot_ff    <= FULL_CODE;
                     rsp_outcome_ff <= OUT_FULL;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_outcome    = rsp_outcome_ff;

   a_strobe_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_SCAN))
      else $error("result strobe without a preceding scan");

   a_no_write_on_hit: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> !hit && scan_last)
      else $error("table written although the address matched");

   a_full_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && (rsp_outcome_ff == OUT_FULL) |-> rsp_slot_ff == FULL_CODE)
      else $error("full outcome with a wrong slot index");

   a_no_rd_on_wr: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.rd_en && mem_ctl.wr_en))
      else $error("table read and written in the same cycle");

   a_idle_after_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == ST_IDLE)
      else $error("sequencer still busy when its result is shown");

endmodule

@@ src/address_registration_table_core.sv @@
// A new start is taken only when the sequencer is idle; a miss compares every slot, while
// a hit in slot k ends the scan at that slot. The scan is paced by the table read port,
// one slot per cycle, with the insert written in the last compare cycle.
// The result strobe comes in the cycle after the scan ends; the receiver cannot stall it.
// Synchronous reset returns the sequencer to idle and marks every slot as holding "00000".
module address_registration_table_core #(
   parameter int SLOTS         = 16,
   parameter int ADDRESS_BYTES = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [art_pkg::ADDR_IN_W-1:0] req_node_address,
   output logic                          rsp_strobe,
   output logic [art_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic [art_pkg::OUTCOME_W-1:0] rsp_outcome
);
   import art_pkg::*;

   localparam int DEPTH  = SLOTS - 1;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(SLOTS);
   localparam int DATA_W = 8 * ADDRESS_BYTES;

   art_mem_ctl_type   mem_ctl;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rd_data;

   art_ctrl #(
      .SLOTS  (SLOTS),
      .CNT_W  (CNT_W),
      .IDX_W  (IDX_W),
      .DATA_W (DATA_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_node_address (req_node_address),
      .rsp_strobe       (rsp_strobe),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_outcome      (rsp_outcome),
      .mem_ctl          (mem_ctl),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_data          (rd_data)
   );

   art_mem #(
      .DEPTH  (DEPTH),
      .IDX_W  (IDX_W),
      .DATA_W (DATA_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import art_pkg::*;

   localparam int SLOTS = 16;
   localparam int ADDRESS_BYTES = 5;
   localparam int ADDR_BITS = 8 * ADDRESS_BYTES;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      art_outcome_type   outcome;
   } registration_type;

   typedef struct packed {
      logic [ADDR_IN_W-1:0] addr;
      logic                 known;
      logic [SLOT_W-1:0]    slot;
      art_outcome_type      outcome;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic [ADDR_IN_W-1:0] req_node_address = '0;
   logic                 busy;
   logic                 rsp_strobe;
   logic [SLOT_W-1:0]    rsp_slot_index;
   logic [OUTCOME_W-1:0] rsp_outcome;

   logic [ADDR_BITS-1:0] slot_table [1:SLOTS-1];
   registration_type     pending_registrations [$];
   int                   mismatch_count = 0;
   int                   items_sent = 0;
   int                   present_seen = 0;
   int                   recorded_seen = 0;
   int                   full_seen = 0;
   int                   cycle_count = 0;

   directed_row_type directed_rows [25] = '{
      '{40'h3030303030, 1'b1, 5'd1,  OUT_PRESENT},
      '{40'h30FFFFFFFF, 1'b1, 5'd1,  OUT_RECORDED},
      '{40'h30FFFFFFFF, 1'b1, 5'd1,  OUT_PRESENT},
      '{40'h3030303030, 1'b1, 5'd2,  OUT_PRESENT},
      '{40'h0000000000, 1'b1, 5'd1,  OUT_RECORDED},
      '{40'hFFFFFFFFFF, 1'b1, 5'd2,  OUT_RECORDED},
      '{40'h3000000000, 1'b1, 5'd3,  OUT_RECORDED},
      '{40'hFFFFFFFFFF, 1'b1, 5'd2,  OUT_PRESENT},
      '{40'hAAAAAAAAAA, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'h5555555555, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'h3132333435, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'h4142434445, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'h0102030405, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'h8000000000, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'h7FFFFFFFFF, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'h0000000001, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'hFEDCBA9876, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'h3130303030, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'h2F30303030, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'h31FFFFFFFF, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'h123456789A, 1'b0, 5'd0,  OUT_PRESENT},
      '{40'hC3A55A3C11, 1'b1, 5'd16, OUT_FULL},
      '{40'h3030303030, 1'b1, 5'd16, OUT_FULL},
      '{40'h123456789A, 1'b1, 5'd15, OUT_PRESENT},
      '{40'h0000000000, 1'b1, 5'd1,  OUT_PRESENT}
   };

   address_registration_table_core #(
      .SLOTS(SLOTS),
      .ADDRESS_BYTES(ADDRESS_BYTES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_node_address(req_node_address),
      .rsp_strobe(rsp_strobe),
      .rsp_slot_index(rsp_slot_index),
      .rsp_outcome(rsp_outcome)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic registration_type register_address(input logic [ADDR_IN_W-1:0] raw);
      logic [ADDR_BITS-1:0] addr;
      int                   free_slot;
      registration_type     r;
      addr = raw[ADDR_BITS-1:0];
      free_slot = 0;
      r.slot = SLOT_W'(SLOTS);
      r.outcome = OUT_FULL;
      for (int i = 1; i < SLOTS; i++) begin
         if (slot_table[i] == addr) begin
            r.slot = SLOT_W'(i);
            r.outcome = OUT_PRESENT;
            break;
         end
         if (free_slot == 0 && slot_table[i][ADDR_BITS-1 -: 8] == FREE_BYTE) begin
            free_slot = i;
         end
      end
      if (r.outcome != OUT_PRESENT && free_slot != 0) begin
         slot_table[free_slot] = addr;
         r.slot = SLOT_W'(free_slot);
         r.outcome = OUT_RECORDED;
      end
      return r;
   endfunction

   task automatic issue_item(input logic [ADDR_IN_W-1:0] addr, input logic known,
                             input registration_type fixed, input logic idle_ok);
      registration_type predicted;
      int               gap;
      if (idle_ok && $urandom_range(99) < 25) begin
         gap = $urandom_range(20, 1);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_node_address <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = register_address(addr);
      pending_registrations.push_back(known ? fixed : predicted);
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_registrations.size() != 0) @(posedge clock);
   endtask

   function automatic logic [ADDR_IN_W-1:0] pick_address();
      logic [ADDR_IN_W-1:0] v;
      int                   roll;
      roll = $urandom_range(99);
      v = {8'($urandom_range(255)), 32'($urandom())};
      if (roll < 55) begin
         v = ADDR_IN_W'(slot_table[$urandom_range(SLOTS - 1, 1)]);
      end else if (roll < 70) begin
         v = ADDR_IN_W'(slot_table[$urandom_range(SLOTS - 1, 1)]);
         v = v ^ (ADDR_IN_W'(1) << $urandom_range(ADDR_BITS - 1));
      end else if (roll < 80) begin
         v = ADDR_IN_W'({ADDRESS_BYTES{FREE_BYTE}});
      end
      return v;
   endfunction

   always @(posedge clock) begin
      registration_type want;
      if (!reset && rsp_strobe) begin
         case (rsp_outcome)
            OUT_PRESENT:  present_seen++;
            OUT_RECORDED: recorded_seen++;
            default:      full_seen++;
         endcase
         if (pending_registrations.size() == 0) begin
            $error("unexpected item: slot %0d, outcome %0d", rsp_slot_index, rsp_outcome);
            mismatch_count++;
         end else begin
            want = pending_registrations.pop_front();
            if (rsp_slot_index !== want.slot) begin
               $error("rsp_slot_index: expected %0d, actual %0d", want.slot, rsp_slot_index);
               mismatch_count++;
            end
            if (rsp_outcome !== want.outcome) begin
               $error("rsp_outcome: expected %0d, actual %0d", want.outcome, rsp_outcome);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d items outstanding.",
                  cycle_count, pending_registrations.size());
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      registration_type fixed;
      for (int i = 1; i < SLOTS; i++) slot_table[i] = {ADDRESS_BYTES{FREE_BYTE}};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         fixed.slot = directed_rows[i].slot;
         fixed.outcome = directed_rows[i].outcome;
         issue_item(directed_rows[i].addr, directed_rows[i].known, fixed, 1'b1);
      end
      drain_results();

      fixed = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 400) drain_results();
         issue_item(pick_address(), 1'b0, fixed, !(n >= 200 && n < 350));
      end

      @(negedge clock);
      start <= 1'b0;
      drain_results();
      repeat (SLOTS + 4) @(posedge clock);

      $display("Sent %0d items over %0d cycles, filling the table and then hitting it hard.",
               items_sent, cycle_count);
      $display("Results: %0d already present, %0d newly recorded, %0d refused as full.",
               present_seen, recorded_seen, full_seen);
      if (mismatch_count == 0 && pending_registrations.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
